### hdl/pne_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the polygon nearest edge block.
// No dependencies; used by the top level, its vertex RAM user and the checker.

package pne_pkg;

   // input action codes
   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_POP    = 2'd1,
      ACT_QUERY  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   // result status codes
   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   // query sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH,
      S_LATCH,
      S_MUL,
      S_MLAST,
      S_DECIDE,
      S_DIV,
      S_BEST,
      S_FIN
   } state_type;

   // products issued to the shared multiplier, in issue order
   typedef enum logic [3:0] {
      M_DXDX,
      M_DYDY,
      M_PXPX,
      M_PYPY,
      M_PXDX,
      M_PYDY,
      M_EXEX,
      M_EYEY,
      M_DXPY,
      M_DYPX,
      M_GAP,
      M_HIHI,
      M_HILO,
      M_LOLO
   } mstep_type;

   localparam int COORD_W  = 24;
   localparam int DIFF_W   = 25;
   localparam int MUL_W    = 26;
   localparam int PROD_W   = 52;
   localparam int DIST_W   = 51;
   localparam int NUM_W    = 100;
   localparam int REM_W    = 52;
   localparam int DIV_STEPS = 51;
   localparam int MINLEN_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes, taken from paddr bit 2
   localparam logic CSR_MIN_EDGE = 1'b0;
   localparam logic [MINLEN_W-1:0] MIN_EDGE_RESET = 16'd1;

endpackage

`default_nettype wire

### hdl/pne_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module pne_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hdl/polygon_nearest_edge.sv
`timescale 1ns / 1ps
`default_nettype none
// Polygon nearest edge top level: vertex table, query sequencer and CSR port.
// Depends on pne_pkg and pne_ram.

// Holds up to MAX_VERTICES polygon vertices in one RAM (x and y side by side)
// and takes append, pop and query beats. Append, pop, an empty query and the
// unused action load the output register when taken. A query reads the
// vertices one by one (last, then 0 up to last) and runs each edge through
// one shared 26x26 multiplier (13 products in 14 issue slots) and, when the
// point projects inside an edge not under the length threshold, a
// one-bit-per-cycle divider of 51 steps, then keeps the nearer edge. A new
// beat is taken only while the sequencer is idle and the output register is
// empty or its beat leaves in the same cycle; a query's result waits in the
// sequencer until that register frees.

module polygon_nearest_edge #(
   parameter int MAX_VERTICES = 64,
   localparam int AW = $clog2(MAX_VERTICES),
   localparam int CW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic signed [pne_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [pne_pkg::COORD_W-1:0]  req_coord_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pne_pkg::DIST_W-1:0]          rsp_dist_sq,
   output logic [AW-1:0]                       rsp_edge_start,
   output logic [CW-1:0]                       rsp_vertex_count,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pne_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pne_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pne_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int CW_ = pne_pkg::COORD_W;

   pne_pkg::state_type state_ff, state_in;

   logic [CW-1:0] cnt_ff;
   logic [pne_pkg::MINLEN_W-1:0] min_len_ff;

   logic signed [CW_-1:0] qx_ff, qy_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic [AW-1:0] a_idx_ff, b_idx_ff, rd_addr_ff;
   logic started_ff, first_ff;

   pne_pkg::mstep_type step_ff, tag_ff;
   logic pvld_ff;
   logic signed [pne_pkg::PROD_W-1:0] prod_ff;
   logic signed [pne_pkg::PROD_W-1:0] len_ff, pp_ff, dp_ff, ee_ff, cr_ff;
   logic [pne_pkg::NUM_W-1:0] num_ff;

   logic [pne_pkg::REM_W-1:0] rem_ff;
   logic [pne_pkg::DIV_STEPS-1:0] quo_ff;
   logic [5:0] dcnt_ff;

   logic [pne_pkg::DIST_W-1:0] cand_ff, best_ff;
   logic [AW-1:0] best_idx_ff;

   logic rsp_valid_ff;
   logic [pne_pkg::DIST_W-1:0] rsp_dist_ff;
   logic [AW-1:0] rsp_edge_ff;
   logic [CW-1:0] rsp_cnt_ff;
   logic [1:0] rsp_status_ff;

   logic [pne_pkg::MINLEN_W-1:0] min_len_in;

   // handshake and bookkeeping
   logic accept, out_free, full, empty, is_query_scan, load_fin, ram_we;
   logic [CW-1:0] cnt_m1;
   logic [AW-1:0] last_idx;
   pne_pkg::action_type act;

   assign act      = pne_pkg::action_type'(req_action);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign full     = (cnt_ff == CW'(MAX_VERTICES));
   assign empty    = (cnt_ff == '0);
   assign cnt_m1   = cnt_ff - 1'b1;
   assign last_idx = cnt_m1[AW-1:0];
   assign is_query_scan = (act == pne_pkg::ACT_QUERY) && !empty;

   // vertex memory: x in the upper half, y in the lower
   logic [2*CW_-1:0] ram_rdata;

   pne_ram #(
      .WIDTH(2 * CW_),
      .DEPTH(MAX_VERTICES)
   ) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(cnt_ff[AW-1:0]),
      .wdata({req_coord_x, req_coord_y}),
      .raddr(rd_addr_ff),
      .rdata(ram_rdata)
   );

   // edge differences
   logic signed [pne_pkg::DIFF_W-1:0] dx, dy, px, py, ex, ey;
   assign dx = {bx_ff[CW_-1], bx_ff} - {ax_ff[CW_-1], ax_ff};
   assign dy = {by_ff[CW_-1], by_ff} - {ay_ff[CW_-1], ay_ff};
   assign px = {qx_ff[CW_-1], qx_ff} - {ax_ff[CW_-1], ax_ff};
   assign py = {qy_ff[CW_-1], qy_ff} - {ay_ff[CW_-1], ay_ff};
   assign ex = {qx_ff[CW_-1], qx_ff} - {bx_ff[CW_-1], bx_ff};
   assign ey = {qy_ff[CW_-1], qy_ff} - {by_ff[CW_-1], by_ff};

   // magnitude of the cross product, split for the wide square
   logic [pne_pkg::PROD_W-1:0] cr_mag;
   logic [24:0] cr_hi, cr_lo;
   assign cr_mag = cr_ff[pne_pkg::PROD_W-1] ? $unsigned(-cr_ff) : $unsigned(cr_ff);
   assign cr_hi  = cr_mag[49:25];
   assign cr_lo  = cr_mag[24:0];

   // shared multiplier operand select
   logic signed [pne_pkg::MUL_W-1:0] ma, mb;
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (step_ff)
         pne_pkg::M_DXDX: begin ma = {dx[24], dx}; mb = {dx[24], dx}; end
         pne_pkg::M_DYDY: begin ma = {dy[24], dy}; mb = {dy[24], dy}; end
         pne_pkg::M_PXPX: begin ma = {px[24], px}; mb = {px[24], px}; end
         pne_pkg::M_PYPY: begin ma = {py[24], py}; mb = {py[24], py}; end
         pne_pkg::M_PXDX: begin ma = {px[24], px}; mb = {dx[24], dx}; end
         pne_pkg::M_PYDY: begin ma = {py[24], py}; mb = {dy[24], dy}; end
         pne_pkg::M_EXEX: begin ma = {ex[24], ex}; mb = {ex[24], ex}; end
         pne_pkg::M_EYEY: begin ma = {ey[24], ey}; mb = {ey[24], ey}; end
         pne_pkg::M_DXPY: begin ma = {dx[24], dx}; mb = {py[24], py}; end
         pne_pkg::M_DYPX: begin ma = {dy[24], dy}; mb = {px[24], px}; end
         pne_pkg::M_HIHI: begin ma = {1'b0, cr_hi}; mb = {1'b0, cr_hi}; end
         pne_pkg::M_HILO: begin ma = {1'b0, cr_hi}; mb = {1'b0, cr_lo}; end
         pne_pkg::M_LOLO: begin ma = {1'b0, cr_lo}; mb = {1'b0, cr_lo}; end
         default:         begin ma = '0; mb = '0; end
      endcase
   end

   // segment case selection
   logic len_small, use_pp, use_ee;
   assign len_small = (len_ff == '0) ||
                      ($unsigned(len_ff) < {{(pne_pkg::PROD_W-pne_pkg::MINLEN_W){1'b0}},
                                             min_len_ff});
   assign use_pp = len_small || dp_ff[pne_pkg::PROD_W-1];
   assign use_ee = !use_pp && (dp_ff > len_ff);

   // one restoring division step
   logic [pne_pkg::REM_W-1:0] r2, r2_sub, len_u;
   logic q_bit;
   assign len_u  = $unsigned(len_ff);
   assign r2     = {rem_ff[pne_pkg::REM_W-2:0], quo_ff[pne_pkg::DIV_STEPS-1]};
   assign q_bit  = (r2 >= len_u);
   assign r2_sub = r2 - len_u;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pne_pkg::S_IDLE:   if (accept && is_query_scan) begin
                               state_in = pne_pkg::S_FETCH;
                            end
         pne_pkg::S_FETCH:  state_in = pne_pkg::S_LATCH;
         pne_pkg::S_LATCH:  state_in = started_ff ? pne_pkg::S_MUL : pne_pkg::S_FETCH;
         pne_pkg::S_MUL:    if (step_ff == pne_pkg::M_LOLO) begin
                               state_in = pne_pkg::S_MLAST;
                            end
         pne_pkg::S_MLAST:  state_in = pne_pkg::S_DECIDE;
         pne_pkg::S_DECIDE: state_in = (use_pp || use_ee) ? pne_pkg::S_BEST
                                                          : pne_pkg::S_DIV;
         pne_pkg::S_DIV:    if (dcnt_ff == '0) begin
                               state_in = pne_pkg::S_BEST;
                            end
         pne_pkg::S_BEST:   state_in = (b_idx_ff == last_idx) ? pne_pkg::S_FIN
                                                              : pne_pkg::S_FETCH;
         pne_pkg::S_FIN:    if (out_free) begin
                               state_in = pne_pkg::S_IDLE;
                            end
         default:           state_in = pne_pkg::S_IDLE;
      endcase
   end

   // handshake and write enables
   always_comb begin
      req_stall = (state_ff != pne_pkg::S_IDLE) || !out_free;
      ram_we    = accept && (act == pne_pkg::ACT_APPEND) && !full;
      load_fin  = (state_ff == pne_pkg::S_FIN) && out_free;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pne_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pvld_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         pvld_ff  <= (state_ff == pne_pkg::S_MUL);
         if (accept) begin
            if (act == pne_pkg::ACT_APPEND && !full) begin
               cnt_ff <= cnt_ff + 1'b1;
            end else if (act == pne_pkg::ACT_POP && !empty) begin
               cnt_ff <= cnt_m1;
            end
         end
         if (accept && !is_query_scan) begin
            rsp_valid_ff <= 1'b1;
         end else if (load_fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // configuration register
   always_comb begin
      min_len_in = min_len_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[2] == pne_pkg::CSR_MIN_EDGE) begin
         min_len_in = csr_pwdata[pne_pkg::MINLEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= pne_pkg::MIN_EDGE_RESET;
      end else begin
         min_len_ff <= min_len_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == pne_pkg::CSR_MIN_EDGE)
                       ? {{(pne_pkg::CSR_DATA_W-pne_pkg::MINLEN_W){1'b0}}, min_len_ff}
                       : '0;

   // query datapath
   always_ff @(posedge clock) begin
      // capture the query point and aim at the last vertex
      if (state_ff == pne_pkg::S_IDLE && accept) begin
         qx_ff      <= req_coord_x;
         qy_ff      <= req_coord_y;
         rd_addr_ff <= last_idx;
         started_ff <= 1'b0;
         first_ff   <= 1'b1;
      end

      // shift the fetched vertex into the edge window
      if (state_ff == pne_pkg::S_LATCH) begin
         ax_ff      <= bx_ff;
         ay_ff      <= by_ff;
         a_idx_ff   <= b_idx_ff;
         bx_ff      <= ram_rdata[2*CW_-1:CW_];
         by_ff      <= ram_rdata[CW_-1:0];
         b_idx_ff   <= rd_addr_ff;
         rd_addr_ff <= started_ff ? rd_addr_ff + 1'b1 : '0;
         started_ff <= 1'b1;
         step_ff    <= pne_pkg::M_DXDX;
      end

      // issue one product a cycle
      if (state_ff == pne_pkg::S_MUL) begin
         prod_ff <= ma * mb;
         tag_ff  <= step_ff;
         if (step_ff != pne_pkg::M_LOLO) begin
            step_ff <= pne_pkg::mstep_type'(step_ff + 4'd1);
         end
      end

      // accumulate the previous product
      if (pvld_ff) begin
         unique case (tag_ff)
            pne_pkg::M_DXDX: len_ff <= prod_ff;
            pne_pkg::M_DYDY: len_ff <= len_ff + prod_ff;
            pne_pkg::M_PXPX: pp_ff  <= prod_ff;
            pne_pkg::M_PYPY: pp_ff  <= pp_ff + prod_ff;
            pne_pkg::M_PXDX: dp_ff  <= prod_ff;
            pne_pkg::M_PYDY: dp_ff  <= dp_ff + prod_ff;
            pne_pkg::M_EXEX: ee_ff  <= prod_ff;
            pne_pkg::M_EYEY: ee_ff  <= ee_ff + prod_ff;
            pne_pkg::M_DXPY: cr_ff  <= prod_ff;
            pne_pkg::M_DYPX: cr_ff  <= cr_ff - prod_ff;
            pne_pkg::M_HIHI: num_ff <= {prod_ff[49:0], 50'b0};
            pne_pkg::M_HILO: num_ff <= num_ff + {23'b0, prod_ff[50:0], 26'b0};
            pne_pkg::M_LOLO: num_ff <= num_ff + {48'b0, $unsigned(prod_ff)};
            default:         num_ff <= num_ff;
         endcase
      end

      // pick the segment case or start the division
      if (state_ff == pne_pkg::S_DECIDE) begin
         cand_ff <= use_pp ? pp_ff[pne_pkg::DIST_W-1:0] : ee_ff[pne_pkg::DIST_W-1:0];
         rem_ff  <= {3'b0, num_ff[pne_pkg::NUM_W-1:pne_pkg::DIV_STEPS]};
         quo_ff  <= num_ff[pne_pkg::DIV_STEPS-1:0];
         dcnt_ff <= 6'(pne_pkg::DIV_STEPS - 1);
      end

      // one quotient bit a cycle
      if (state_ff == pne_pkg::S_DIV) begin
         rem_ff  <= q_bit ? r2_sub : r2;
         quo_ff  <= {quo_ff[pne_pkg::DIV_STEPS-2:0], q_bit};
         dcnt_ff <= dcnt_ff - 1'b1;
         if (dcnt_ff == '0) begin
            cand_ff <= {quo_ff[pne_pkg::DIV_STEPS-2:0], q_bit};
         end
      end

      // keep the strictly nearer edge
      if (state_ff == pne_pkg::S_BEST) begin
         first_ff <= 1'b0;
         if (first_ff || cand_ff < best_ff) begin
            best_ff     <= cand_ff;
            best_idx_ff <= a_idx_ff;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (accept && !is_query_scan) begin
         rsp_dist_ff <= '0;
         rsp_edge_ff <= '0;
         unique case (act)
            pne_pkg::ACT_APPEND: begin
               rsp_cnt_ff    <= full ? cnt_ff : cnt_ff + 1'b1;
               rsp_status_ff <= full ? pne_pkg::STS_FULL : pne_pkg::STS_OK;
            end
            pne_pkg::ACT_POP: begin
               rsp_cnt_ff    <= empty ? cnt_ff : cnt_m1;
               rsp_status_ff <= empty ? pne_pkg::STS_EMPTY : pne_pkg::STS_OK;
            end
            pne_pkg::ACT_QUERY: begin
               rsp_cnt_ff    <= cnt_ff;
               rsp_status_ff <= pne_pkg::STS_EMPTY;
            end
            default: begin
               rsp_cnt_ff    <= cnt_ff;
               rsp_status_ff <= pne_pkg::STS_OK;
            end
         endcase
      end else if (load_fin) begin
         rsp_dist_ff   <= best_ff;
         rsp_edge_ff   <= best_idx_ff;
         rsp_cnt_ff    <= cnt_ff;
         rsp_status_ff <= pne_pkg::STS_OK;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dist_sq      = rsp_dist_ff;
   assign rsp_edge_start   = rsp_edge_ff;
   assign rsp_vertex_count = rsp_cnt_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

### hdl/pne_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for polygon_nearest_edge, attached by bind.
// Depends on pne_pkg and the top level's port list.

module pne_checker #(
   parameter int MAX_VERTICES = 64,
   localparam int AW = $clog2(MAX_VERTICES),
   localparam int CW = $clog2(MAX_VERTICES + 1)
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [1:0]                          req_action,
   input logic signed [pne_pkg::COORD_W-1:0]  req_coord_x,
   input logic signed [pne_pkg::COORD_W-1:0]  req_coord_y,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [pne_pkg::DIST_W-1:0]          rsp_dist_sq,
   input logic [AW-1:0]                       rsp_edge_start,
   input logic [CW-1:0]                       rsp_vertex_count,
   input logic [1:0]                          rsp_status,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [pne_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input logic [pne_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input logic [pne_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input logic                                csr_pready
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dist_sq) &&
      $stable(rsp_edge_start) && $stable(rsp_vertex_count) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   // an empty-table answer carries no distance and no vertices
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pne_pkg::STS_EMPTY |->
      rsp_dist_sq == '0 && rsp_edge_start == '0 && rsp_vertex_count == '0)
      else $error("empty status with nonzero fields");

   // a full-table answer only comes at capacity
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pne_pkg::STS_FULL |->
      rsp_vertex_count == CW'(MAX_VERTICES) && rsp_dist_sq == '0)
      else $error("full status below capacity");

   // count never passes capacity and a distance's edge lies below it
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_vertex_count <= CW'(MAX_VERTICES) &&
      (rsp_status != pne_pkg::STS_OK || rsp_dist_sq == '0 ||
       CW'(rsp_edge_start) < rsp_vertex_count))
      else $error("vertex count or edge index out of range");

endmodule

bind polygon_nearest_edge pne_checker #(.MAX_VERTICES(MAX_VERTICES)) u_pne_checker (.*);

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for polygon_nearest_edge: vertex appends, pops and queries
// checked against an in-bench nearest-edge predictor. Depends on pne_pkg.

module testbench;

   localparam int      NVERT      = 64;
   localparam longint  CYCLE_CAP  = 20000000;
   localparam int      DRAIN_WAIT = 6000;

   typedef struct {
      pne_pkg::action_type     act;
      logic signed [23:0]      cx;
      logic signed [23:0]      cy;
   } vertex_op_type;

   typedef struct {
      logic [50:0]         dist_val;
      logic [5:0]          edge_idx;
      logic [6:0]          count;
      pne_pkg::status_type sts;
   } answer_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_action = '0;
   logic signed [23:0] req_coord_x = '0;
   logic signed [23:0] req_coord_y = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [50:0] rsp_dist_sq;
   logic [5:0] rsp_edge_start;
   logic [6:0] rsp_vertex_count;
   logic [1:0] rsp_status;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [pne_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [pne_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [pne_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   polygon_nearest_edge #(.MAX_VERTICES(NVERT)) uut (.*);

   // predictor state
   logic signed [23:0] vert_x [NVERT];
   logic signed [23:0] vert_y [NVERT];
   int                 vert_total = 0;
   logic [15:0]        min_len_sq = pne_pkg::MIN_EDGE_RESET;

   vertex_op_type pending_beats[$];
   answer_type    expected_answers[$];
   int         mismatches = 0;
   int         beats_taken = 0;
   int         gen_count = 0;
   int         queued_total = 0;
   longint     cycles = 0;
   logic       beat_taken = 0;
   int         gap_left = 0;
   int         stall_left = 0;
   int         hold_left = 0;
   logic       hold_done = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // squared distance from point q to edge a->b
   function automatic logic [50:0] edge_dist_sq(longint ax, longint ay, longint bx,
                                                longint by, longint qx, longint qy);
      longint dx, dy, px, py, len_sq, pp, dp, cr, ex, ey;
      logic [63:0]  mag;
      logic [127:0] num;
      dx = bx - ax; dy = by - ay;
      px = qx - ax; py = qy - ay;
      len_sq = dx * dx + dy * dy;
      pp = px * px + py * py;
      if (len_sq == 0 || len_sq < longint'(min_len_sq)) return pp[50:0];
      dp = px * dx + py * dy;
      if (dp < 0) return pp[50:0];
      if (dp > len_sq) begin
         ex = qx - bx; ey = qy - by;
         return 51'(ex * ex + ey * ey);
      end
      cr = dx * py - dy * px;
      mag = (cr < 0) ? 64'(-cr) : 64'(cr);
      num = 128'(mag) * 128'(mag);
      num = num / 128'(len_sq);
      return num[50:0];
   endfunction

   function automatic answer_type predict_nearest(vertex_op_type op);
      answer_type  a;
      int          last;
      logic [50:0] d;
      a.dist_val = '0; a.edge_idx = '0; a.sts = pne_pkg::STS_OK;
      case (op.act)
         pne_pkg::ACT_APPEND: begin
            if (vert_total >= NVERT) a.sts = pne_pkg::STS_FULL;
            else begin
               vert_x[vert_total] = op.cx;
               vert_y[vert_total] = op.cy;
               vert_total++;
            end
         end
         pne_pkg::ACT_POP: begin
            if (vert_total == 0) a.sts = pne_pkg::STS_EMPTY;
            else vert_total--;
         end
         pne_pkg::ACT_QUERY: begin
            if (vert_total == 0) a.sts = pne_pkg::STS_EMPTY;
            else begin
               last = vert_total - 1;
               a.dist_val = edge_dist_sq(vert_x[last], vert_y[last], vert_x[0], vert_y[0],
                                         op.cx, op.cy);
               a.edge_idx = 6'(last);
               for (int i = 0; i < last; i++) begin
                  d = edge_dist_sq(vert_x[i], vert_y[i], vert_x[i+1], vert_y[i+1],
                                   op.cx, op.cy);
                  if (d < a.dist_val) begin
                     a.dist_val = d;
                     a.edge_idx = 6'(i);
                  end
               end
            end
         end
         default: ;
      endcase
      a.count = 7'(vert_total);
      return a;
   endfunction

   function automatic void flag_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch @%0t: %s", $realtime, what);
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // request side: predict on every accepted beat
   always @(posedge clock) begin
      beat_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         vertex_op_type op;
         op.act = pne_pkg::action_type'(req_action);
         op.cx = req_coord_x;
         op.cy = req_coord_y;
         expected_answers.insert(expected_answers.size(), predict_nearest(op));
         beats_taken <= beats_taken + 1;
      end
   end

   // driver: next beat or a gap, changes at falling edge
   always @(negedge clock) begin
      if (!reset && (!req_valid || beat_taken)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 0;
         end else if (pending_beats.size() > 0) begin
            vertex_op_type op;
            int r;
            op = pending_beats.pop_front();
            req_action <= op.act;
            req_coord_x <= op.cx;
            req_coord_y <= op.cy;
            req_valid <= 1;
            r = $urandom_range(0, 99);
            if ((beats_taken % 128) < 40 || r < 60) gap_left <= 0;
            else if (r < 92) gap_left <= $urandom_range(1, 3);
            else gap_left <= $urandom_range(10, 40);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver stall, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (!hold_done && beats_taken >= 150) begin
         hold_done <= 1;
         hold_left <= 800;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         rsp_stall <= 0;
         if ((cycles % 4000) > 1500) begin
            if (r < 20) stall_left <= $urandom_range(1, 3);
            else if (r < 24) stall_left <= $urandom_range(20, 80);
         end
      end
   end

   // monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         answer_type e;
         if (expected_answers.size() == 0) flag_mismatch("result beat with none expected");
         else begin
            e = expected_answers.pop_front();
            if (rsp_dist_sq !== e.dist_val)
               flag_mismatch($sformatf("dist_sq exp %0d got %0d", e.dist_val, rsp_dist_sq));
            if (rsp_edge_start !== e.edge_idx)
               flag_mismatch($sformatf("edge_start exp %0d got %0d",
                                       e.edge_idx, rsp_edge_start));
            if (rsp_vertex_count !== e.count)
               flag_mismatch($sformatf("vertex_count exp %0d got %0d",
                                       e.count, rsp_vertex_count));
            if (rsp_status !== e.sts)
               flag_mismatch($sformatf("status exp %0d got %0d", e.sts, rsp_status));
         end
      end
   end

   task automatic queue_op(pne_pkg::action_type act, int x, int y);
      vertex_op_type op;
      op.act = act;
      op.cx = 24'(x);
      op.cy = 24'(y);
      pending_beats.insert(pending_beats.size(), op);
      queued_total++;
      if (act == pne_pkg::ACT_APPEND && gen_count < NVERT) gen_count++;
      if (act == pne_pkg::ACT_POP && gen_count > 0) gen_count--;
   endtask

   function automatic int rand_coord();
      case ($urandom_range(0, 5))
         0, 1: return $urandom_range(0, 4096) - 2048;
         2: return $urandom_range(0, 262144) - 131072;
         3: return int'($signed(24'($urandom)));
         4: return $urandom_range(0, 1) ? 8388607 : -8388608;
         default: return $urandom_range(0, 64) - 32;
      endcase
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_answers.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   // register write then read back
   task automatic write_min_len(logic [15:0] val);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {pne_pkg::CSR_MIN_EDGE, 2'b00};
      csr_pwdata <= {16'd0, val};
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_pwrite <= 0; csr_penable <= 0;
      min_len_sq = val;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      if (csr_prdata[15:0] !== val)
         flag_mismatch($sformatf("min_edge_len_sq read %0d exp %0d", csr_prdata[15:0], val));
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0;
   endtask

   // random polygons with queries, mixed with some noise
   task automatic random_phase(int beats);
      int target, n, stop;
      target = queued_total + beats;
      stop = 0;
      while (!stop) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
               queue_op(pne_pkg::action_type'($urandom_range(0, 3)), rand_coord(),
                        rand_coord());
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, NVERT) : $urandom_range(1, 8);
            while (gen_count > n) queue_op(pne_pkg::ACT_POP, rand_coord(), rand_coord());
            while (gen_count < n) queue_op(pne_pkg::ACT_APPEND, rand_coord(), rand_coord());
            repeat ($urandom_range(2, 6))
               queue_op(pne_pkg::ACT_QUERY, rand_coord(), rand_coord());
         end
         if (queued_total >= target) stop = 1;
         else if (pending_beats.size() > 40) begin
            while (pending_beats.size() >= 20) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // zero threshold, directed corner cases
      write_min_len(16'd0);
      queue_op(pne_pkg::ACT_QUERY, 0, 0);
      queue_op(pne_pkg::ACT_POP, 0, 0);
      queue_op(pne_pkg::ACT_NONE, 8388607, -8388608);
      queue_op(pne_pkg::ACT_APPEND, -8388608, -8388608);
      queue_op(pne_pkg::ACT_QUERY, 8388607, 8388607);
      queue_op(pne_pkg::ACT_APPEND, 8388607, 8388607);
      queue_op(pne_pkg::ACT_QUERY, 0, 0);
      queue_op(pne_pkg::ACT_QUERY, 8388607, -8388608);
      queue_op(pne_pkg::ACT_QUERY, -8388608, 8388607);
      queue_op(pne_pkg::ACT_APPEND, 8388607, 8388607);
      queue_op(pne_pkg::ACT_QUERY, 100, -100);
      queue_op(pne_pkg::ACT_APPEND, -256, 4096);
      queue_op(pne_pkg::ACT_QUERY, -1, -1);
      queue_op(pne_pkg::ACT_NONE, -1, -1);
      queue_op(pne_pkg::ACT_POP, 0, 0);
      queue_op(pne_pkg::ACT_POP, 0, 0);
      queue_op(pne_pkg::ACT_POP, 0, 0);
      queue_op(pne_pkg::ACT_POP, 0, 0);
      queue_op(pne_pkg::ACT_APPEND, 0, 0);
      queue_op(pne_pkg::ACT_APPEND, 1, 0);
      queue_op(pne_pkg::ACT_APPEND, 1, 1);
      queue_op(pne_pkg::ACT_QUERY, 0, 1);
      random_phase(160);
      wait_idle();

      // widest threshold, plus a full table
      write_min_len(16'hFFFF);
      while (gen_count < NVERT) queue_op(pne_pkg::ACT_APPEND, rand_coord(), rand_coord());
      queue_op(pne_pkg::ACT_APPEND, 5, 5);
      queue_op(pne_pkg::ACT_APPEND, -5, -5);
      queue_op(pne_pkg::ACT_QUERY, rand_coord(), rand_coord());
      queue_op(pne_pkg::ACT_APPEND, rand_coord(), rand_coord());
      random_phase(170);
      wait_idle();

      write_min_len(16'($urandom));
      random_phase(170);
      wait_idle();

      write_min_len(16'd1);
      random_phase(170);
      wait_idle();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
